>>> hdl/rlbw_pkg.sv
`timescale 1ns / 1ps
package rlbw_pkg;

  localparam int LED_COUNT = 4;
  localparam int INIT_LEN  = 14;

  localparam logic [7:0] RED_LIMIT_RST   = 8'h5c;
  localparam logic [7:0] GREEN_LIMIT_RST = 8'h38;
  localparam logic [7:0] BLUE_LIMIT_RST  = 8'h67;
  localparam logic [7:0] BRIGHT_RST      = 8'hff;

  localparam logic [7:0] BASE_LO   = 8'h15;
  localparam logic [7:0] BASE_HI   = 8'h18;
  localparam logic [7:0] REG_MODE  = 8'h01;
  localparam logic [7:0] MODE_WAKE = 8'h20;
  localparam logic [7:0] MODE_STBY = 8'h00;

  // command codes
  localparam logic [2:0] FN_COLOUR = 3'd0;
  localparam logic [2:0] FN_BRIGHT = 3'd1;
  localparam logic [2:0] FN_STBY   = 3'd2;
  localparam logic [2:0] FN_WAKE   = 3'd3;
  localparam logic [2:0] FN_INIT   = 3'd4;
  localparam logic [2:0] FN_RAW    = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_RED   = 2'd0;
  localparam logic [1:0] CFG_GREEN = 2'd1;
  localparam logic [1:0] CFG_BLUE  = 2'd2;

  // microcode operations
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_STORE = 3'd1;
  localparam logic [2:0] OP_MUL1  = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_MUL2  = 3'd4;
  localparam logic [2:0] OP_LED   = 3'd5;
  localparam logic [2:0] OP_INIT  = 3'd6;
  localparam logic [2:0] OP_PAIR  = 3'd7;

  localparam int STEP_W = 4;

  // program steps
  localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] ST_STORE = 4'd1;
  localparam logic [STEP_W-1:0] ST_MUL1  = 4'd2;
  localparam logic [STEP_W-1:0] ST_DIV   = 4'd3;
  localparam logic [STEP_W-1:0] ST_MUL2  = 4'd4;
  localparam logic [STEP_W-1:0] ST_LED   = 4'd5;
  localparam logic [STEP_W-1:0] ST_INIT  = 4'd6;
  localparam logic [STEP_W-1:0] ST_PAIR  = 4'd7;
  localparam logic [STEP_W-1:0] ST_RAW   = 4'd8;

  typedef struct packed {
    logic [2:0]        op;
    logic              raw;   // emit step passes the raw write through
    logic [STEP_W-1:0] next;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_IDLE, raw: 1'b0, next: ST_IDLE};
    case (pc)
      ST_STORE: w = '{op: OP_STORE, raw: 1'b0, next: ST_MUL1};
      ST_MUL1:  w = '{op: OP_MUL1,  raw: 1'b0, next: ST_DIV};
      ST_DIV:   w = '{op: OP_DIV,   raw: 1'b0, next: ST_MUL2};
      ST_MUL2:  w = '{op: OP_MUL2,  raw: 1'b0, next: ST_LED};
      ST_LED:   w = '{op: OP_LED,   raw: 1'b0, next: ST_IDLE};
      ST_INIT:  w = '{op: OP_INIT,  raw: 1'b0, next: ST_IDLE};
      ST_PAIR:  w = '{op: OP_PAIR,  raw: 1'b0, next: ST_IDLE};
      ST_RAW:   w = '{op: OP_PAIR,  raw: 1'b1, next: ST_IDLE};
      default:  w = '{op: OP_IDLE,  raw: 1'b0, next: ST_IDLE};
    endcase
    return w;
  endfunction

  // driver setup sequence: {register, value}
  function automatic logic [15:0] init_entry(input logic [3:0] idx);
    logic [15:0] e;
    case (idx)
      4'd0:    e = {8'h04, 8'h00};
      4'd1:    e = {8'h05, 8'h3f};
      4'd2:    e = {8'h0f, 8'h01};
      4'd3:    e = {8'h10, 8'h3f};
      4'd4:    e = {8'h11, 8'h00};
      4'd5:    e = {8'h12, 8'h00};
      4'd6:    e = {8'h13, 8'h00};
      4'd7:    e = {8'h14, 8'h00};
      4'd8:    e = {8'h15, 8'h00};
      4'd9:    e = {8'h16, 8'h00};
      4'd10:   e = {8'h17, 8'h00};
      4'd11:   e = {8'h18, 8'h00};
      4'd12:   e = {8'h19, 8'h00};
      4'd13:   e = {8'h1a, 8'h00};
      default: e = 16'h0000;
    endcase
    return e;
  endfunction

  // exact floor(x / 255) for x <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

>>> hdl/rlbw_in_if.sv
`timescale 1ns / 1ps
interface rlbw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] led;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] level;
  logic       chip;
  logic [7:0] reg_addr;
  logic [7:0] reg_data;

  modport source (output valid, func, led, red, green, blue, level, chip, reg_addr,
                  reg_data, input ready);
  modport sink (input valid, func, led, red, green, blue, level, chip, reg_addr,
                reg_data, output ready);
endinterface

>>> hdl/rlbw_out_if.sv
`timescale 1ns / 1ps
interface rlbw_out_if;
  logic       valid;
  logic       ready;
  logic       target_chip;
  logic [7:0] target_reg;
  logic [7:0] write_value;
  logic       last;

  modport source (output valid, target_chip, target_reg, write_value, last,
                  input ready);
  modport sink (input valid, target_chip, target_reg, write_value, last,
                output ready);
endinterface

>>> hdl/rgb_led_bar_brightness_writer_core.sv
`timescale 1ns / 1ps
// Command unit for a four-LED RGB bar driven by two LED driver chips.
// in_ch takes one command item (valid/ready); out_ch gives one driver register
// write per item, with last set on the final write of a command.
// cfg_we/cfg_index/cfg_wdata load the red, green and blue full-scale limits;
// write them only while no command is in flight.
// A small microcode table steps a shared 8x8 multiplier: each colour channel
// passes through its steps in turn (multiply, divide by 255, multiply by limit,
// emit). Standby, wake and raw writes emit one write per cycle while out_ch is
// ready; init emits 28 writes back to back while out_ch is ready.
// in_ch.ready is high only while the sequencer sits at its idle step; the
// next command is taken while the last write still waits in the output
// register. A stalled out_ch holds the sequencer at its emit step.
// After reset the stored colours are zero, brightness is 255 and the limits
// are 92 (red), 56 (green) and 103 (blue).
module rgb_led_bar_brightness_writer_core (
  input  logic       clk,
  input  logic       rst_n,
  rlbw_in_if.sink    in_ch,
  rlbw_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import rlbw_pkg::*;

  localparam int K_W = $clog2(LED_COUNT) > 0 ? $clog2(LED_COUNT) : 1;

  logic [STEP_W-1:0] pc_r, pc_nxt;
  ctrl_t             cw;

  logic [7:0] red_lim_r, green_lim_r, blue_lim_r;
  logic [7:0] bright_r;
  logic [7:0] colour_r [LED_COUNT][3];   // red, green, blue per LED

  logic [K_W-1:0] k_r;
  logic [1:0]     ch_r;     // 0 blue, 1 red, 2 green
  logic           all_r;
  logic           store_r;
  logic           chip_r;
  logic           wake_r;
  logic [3:0]     ii_r;
  logic [7:0]     rd_r, gn_r, bl_r;
  logic [7:0]     addr_r, data_r;

  logic [15:0] mul_r;
  logic [7:0]  q_r;

  logic       out_valid_r;
  logic       out_chip_r;
  logic [7:0] out_reg_r;
  logic [7:0] out_val_r;
  logic       out_last_r;

  logic       slot_free;
  logic       emit_go;
  logic       in_go;
  logic       e_chip;
  logic [7:0] e_reg;
  logic [7:0] e_val;
  logic       e_last;
  logic [7:0] mul_a, mul_b;
  logic [7:0] lim_sel;
  logic [7:0] col_sel;
  logic [7:0] led_base;
  logic [15:0] ini;
  logic        led_all;
  logic        last_led;

  assign cw        = ucode(pc_r);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (cw.op == OP_IDLE);
  assign in_go     = in_ch.valid && in_ch.ready;
  assign led_all   = (in_ch.led >= 8'(LED_COUNT));
  assign last_led  = (k_r == K_W'(LED_COUNT - 1)) || !all_r;

  always_comb begin
    case (ch_r)
      2'd0:    begin col_sel = colour_r[k_r][2]; lim_sel = blue_lim_r;  end
      2'd1:    begin col_sel = colour_r[k_r][0]; lim_sel = red_lim_r;   end
      default: begin col_sel = colour_r[k_r][1]; lim_sel = green_lim_r; end
    endcase
  end

  assign mul_a = (cw.op == OP_MUL1) ? col_sel : q_r;
  assign mul_b = (cw.op == OP_MUL1) ? bright_r : lim_sel;

  // LED 0/1 on chip 0, LED 2/3 on chip 1; odd LEDs sit at the upper base
  assign led_base = k_r[0] ? BASE_HI : BASE_LO;
  assign ini      = init_entry(ii_r);

  always_comb begin
    e_chip = chip_r;
    e_reg  = REG_MODE;
    e_val  = wake_r ? MODE_WAKE : MODE_STBY;
    e_last = chip_r;
    case (cw.op)
      OP_LED: begin
        e_chip = (K_W > 1) ? k_r[K_W-1] : 1'b0;
        e_reg  = led_base + {6'd0, ch_r};
        e_val  = div255(mul_r);
        e_last = (ch_r == 2'd2) && last_led;
      end
      OP_INIT: begin
        e_reg  = ini[15:8];
        e_val  = ini[7:0];
        e_last = chip_r && (ii_r == 4'(INIT_LEN - 1));
      end
      OP_PAIR: begin
        if (cw.raw) begin
          e_reg  = addr_r;
          e_val  = data_r;
          e_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign emit_go = slot_free &&
                   (cw.op == OP_LED || cw.op == OP_INIT || cw.op == OP_PAIR);

  // step sequencing with conditional jumps at the emit steps
  always_comb begin
    pc_nxt = pc_r;
    case (cw.op)
      OP_IDLE: begin
        if (in_go) begin
          case (in_ch.func)
            FN_COLOUR: pc_nxt = ST_STORE;
            FN_BRIGHT: pc_nxt = ST_MUL1;
            FN_STBY:   pc_nxt = ST_PAIR;
            FN_WAKE:   pc_nxt = ST_PAIR;
            FN_INIT:   pc_nxt = ST_INIT;
            FN_RAW:    pc_nxt = ST_RAW;
            default:   pc_nxt = ST_IDLE;
          endcase
        end
      end
      OP_STORE, OP_MUL1, OP_DIV, OP_MUL2: pc_nxt = cw.next;
      OP_LED: begin
        if (emit_go) begin
          if (ch_r != 2'd2)  pc_nxt = ST_MUL1;
          else if (!last_led) pc_nxt = store_r ? ST_STORE : ST_MUL1;
          else               pc_nxt = cw.next;
        end
      end
      OP_INIT: begin
        if (emit_go && e_last) pc_nxt = cw.next;
      end
      OP_PAIR: begin
        if (emit_go && e_last) pc_nxt = cw.next;
      end
      default: pc_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_IDLE;
      red_lim_r   <= RED_LIMIT_RST;
      green_lim_r <= GREEN_LIMIT_RST;
      blue_lim_r  <= BLUE_LIMIT_RST;
      bright_r    <= BRIGHT_RST;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      ch_r        <= 2'd0;
      all_r       <= 1'b0;
      store_r     <= 1'b0;
      chip_r      <= 1'b0;
      wake_r      <= 1'b0;
      ii_r        <= 4'd0;
      for (int i = 0; i < LED_COUNT; i++) begin
        for (int c = 0; c < 3; c++) begin
          colour_r[i][c] <= 8'd0;
        end
      end
    end else begin
      pc_r <= pc_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_RED:   red_lim_r   <= cfg_wdata;
          CFG_GREEN: green_lim_r <= cfg_wdata;
          CFG_BLUE:  blue_lim_r  <= cfg_wdata;
          default: ;
        endcase
      end

      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_go) begin
        ch_r   <= 2'd0;
        chip_r <= (in_ch.func == FN_RAW) ? in_ch.chip : 1'b0;
        wake_r <= (in_ch.func == FN_WAKE);
        ii_r   <= 4'd0;
        case (in_ch.func)
          FN_COLOUR: begin
            k_r     <= led_all ? '0 : in_ch.led[K_W-1:0];
            all_r   <= led_all;
            store_r <= 1'b1;
          end
          FN_BRIGHT: begin
            bright_r <= in_ch.level;
            k_r      <= '0;
            all_r    <= 1'b1;
            store_r  <= 1'b0;
          end
          FN_INIT: begin
            for (int i = 0; i < LED_COUNT; i++) begin
              for (int c = 0; c < 3; c++) begin
                colour_r[i][c] <= 8'd0;
              end
            end
          end
          default: ;
        endcase
      end

      if (cw.op == OP_STORE) begin
        colour_r[k_r][0] <= rd_r;
        colour_r[k_r][1] <= gn_r;
        colour_r[k_r][2] <= bl_r;
      end

      if (emit_go) begin
        case (cw.op)
          OP_LED: begin
            if (ch_r != 2'd2) begin
              ch_r <= ch_r + 2'd1;
            end else if (!last_led) begin
              ch_r <= 2'd0;
              k_r  <= k_r + K_W'(1);
            end
          end
          OP_INIT: begin
            chip_r <= !chip_r;
            if (chip_r) ii_r <= ii_r + 4'd1;
          end
          OP_PAIR: begin
            if (!cw.raw) chip_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_go) begin
      rd_r   <= in_ch.red;
      gn_r   <= in_ch.green;
      bl_r   <= in_ch.blue;
      addr_r <= in_ch.reg_addr;
      data_r <= in_ch.reg_data;
    end
    if (cw.op == OP_MUL1 || cw.op == OP_MUL2) begin
      mul_r <= mul_a * mul_b;
    end
    if (cw.op == OP_DIV) begin
      q_r <= div255(mul_r);
    end
    if (emit_go) begin
      out_chip_r <= e_chip;
      out_reg_r  <= e_reg;
      out_val_r  <= e_val;
      out_last_r <= e_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.target_chip = out_chip_r;
  assign out_ch.target_reg  = out_reg_r;
  assign out_ch.write_value = out_val_r;
  assign out_ch.last        = out_last_r;

endmodule

>>> tb/sv/tb_rgb_led_bar_brightness_writer_core.sv
`timescale 1ns / 1ps
module tb_rgb_led_bar_brightness_writer_core;
  import rlbw_pkg::*;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] led;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] level;
    logic       chip;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
  } led_cmd_t;

  typedef struct packed {
    logic       target_chip;
    logic [7:0] target_reg;
    logic [7:0] write_value;
    logic       last;
  } drv_write_t;

  // driver setup sequence sent on init, same list for both chips
  localparam logic [7:0] SETUP_ADDR [0:13] = '{8'h04, 8'h05, 8'h0f, 8'h10, 8'h11, 8'h12,
                                               8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
                                               8'h19, 8'h1a};
  localparam logic [7:0] SETUP_DATA [0:13] = '{8'h00, 8'h3f, 8'h01, 8'h3f, 8'h00, 8'h00,
                                               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                               8'h00, 8'h00};
  localparam logic [2:0] FN_NONE_A = 3'd6;
  localparam logic [2:0] FN_NONE_B = 3'd7;
  localparam int SETTLE_CYCLES = 64;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  rlbw_in_if  in_ch ();
  rlbw_out_if out_ch ();

  rgb_led_bar_brightness_writer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the block state
  logic [7:0] colour_mem [0:11];
  logic [7:0] bright_lvl;
  logic [7:0] lim_red;
  logic [7:0] lim_green;
  logic [7:0] lim_blue;

  led_cmd_t   pending_cmds [$];
  drv_write_t exp_writes [$];
  led_cmd_t   drv_cmd;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         err_count;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [7:0] lim);
    int t;
    t = (int'(c) * int'(bright_lvl)) / 255;
    return 8'((t * int'(lim)) / 255);
  endfunction

  function automatic void push_write(input logic chip_sel, input logic [7:0] addr,
                                     input logic [7:0] val);
    drv_write_t w;
    w = '{target_chip: chip_sel, target_reg: addr, write_value: val, last: 1'b0};
    exp_writes.push_back(w);
  endfunction

  // blue, red, green from the stored colour of one led
  function automatic void push_led(input logic [1:0] k);
    logic       chip_sel;
    logic [7:0] base;
    int         s;
    chip_sel = k[1];
    base     = k[0] ? BASE_HI : BASE_LO;
    s        = int'(k) * 3;
    push_write(chip_sel, base, scale_chan(colour_mem[s + 2], lim_blue));
    push_write(chip_sel, base + 8'd1, scale_chan(colour_mem[s], lim_red));
    push_write(chip_sel, base + 8'd2, scale_chan(colour_mem[s + 1], lim_green));
  endfunction

  function automatic void store_colour(input logic [1:0] k, input led_cmd_t c);
    colour_mem[int'(k) * 3]     = c.red;
    colour_mem[int'(k) * 3 + 1] = c.green;
    colour_mem[int'(k) * 3 + 2] = c.blue;
  endfunction

  function automatic void predict_writes(input led_cmd_t c);
    int first;
    first = exp_writes.size();
    case (c.func)
      FN_COLOUR: begin
        if (c.led >= 8'(LED_COUNT)) begin
          for (int i = 0; i < LED_COUNT; i++) begin
            store_colour(2'(i), c);
            push_led(2'(i));
          end
        end else begin
          store_colour(c.led[1:0], c);
          push_led(c.led[1:0]);
        end
      end
      FN_BRIGHT: begin
        bright_lvl = c.level;
        for (int i = 0; i < LED_COUNT; i++) push_led(2'(i));
      end
      FN_STBY: begin
        push_write(1'b0, REG_MODE, MODE_STBY);
        push_write(1'b1, REG_MODE, MODE_STBY);
      end
      FN_WAKE: begin
        push_write(1'b0, REG_MODE, MODE_WAKE);
        push_write(1'b1, REG_MODE, MODE_WAKE);
      end
      FN_INIT: begin
        for (int i = 0; i < INIT_LEN; i++) begin
          push_write(1'b0, SETUP_ADDR[i], SETUP_DATA[i]);
          push_write(1'b1, SETUP_ADDR[i], SETUP_DATA[i]);
        end
        for (int i = 0; i < 12; i++) colour_mem[i] = 8'h00;
      end
      FN_RAW: push_write(c.chip, c.reg_addr, c.reg_data);
      default: ;
    endcase
    if (exp_writes.size() > first) exp_writes[exp_writes.size() - 1].last = 1'b1;
  endfunction

  function automatic void note_error(input string what, input drv_write_t want,
                                     input drv_write_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t %s: expected chip %0d reg %02h val %02h last %0d,",
               $realtime, what, want.target_chip, want.target_reg, want.write_value,
               want.last);
      $display("  got chip %0d reg %02h val %02h last %0d",
               got.target_chip, got.target_reg, got.write_value, got.last);
    end
  endfunction

  // command driver
  always @(posedge clk) begin : drive_p
    led_cmd_t nxt;
    logic     take;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      take = !in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predict_writes(drv_cmd);
        take = 1'b1;
      end
      if (take) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_cmds.pop_front();
          drv_cmd        <= nxt;
          in_ch.func     <= nxt.func;
          in_ch.led      <= nxt.led;
          in_ch.red      <= nxt.red;
          in_ch.green    <= nxt.green;
          in_ch.blue     <= nxt.blue;
          in_ch.level    <= nxt.level;
          in_ch.chip     <= nxt.chip;
          in_ch.reg_addr <= nxt.reg_addr;
          in_ch.reg_data <= nxt.reg_data;
          in_ch.valid    <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // write monitor
  always @(posedge clk) begin : watch_p
    drv_write_t got;
    drv_write_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{target_chip: out_ch.target_chip, target_reg: out_ch.target_reg,
                write_value: out_ch.write_value, last: out_ch.last};
        if (exp_writes.size() == 0) begin
          note_error("unexpected write", '0, got);
        end else begin
          want = exp_writes.pop_front();
          if (got.target_chip !== want.target_chip || got.target_reg !== want.target_reg ||
              got.write_value !== want.write_value || got.last !== want.last)
            note_error("write mismatch", want, got);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic led_cmd_t make_cmd(input logic [2:0] func, input logic [7:0] led,
                                        input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] level,
                                        input logic chip, input logic [7:0] addr,
                                        input logic [7:0] data);
    return '{func: func, led: led, red: r, green: g, blue: b, level: level, chip: chip,
             reg_addr: addr, reg_data: data};
  endfunction

  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return 8'($urandom_range(255));
  endfunction

  function automatic led_cmd_t rand_cmd();
    led_cmd_t c;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 35)      c.func = FN_COLOUR;
    else if (pick < 55) c.func = FN_BRIGHT;
    else if (pick < 62) c.func = FN_STBY;
    else if (pick < 69) c.func = FN_WAKE;
    else if (pick < 75) c.func = FN_INIT;
    else if (pick < 95) c.func = FN_RAW;
    else                c.func = ($urandom_range(1) == 0) ? FN_NONE_A : FN_NONE_B;
    c.led      = ($urandom_range(4) == 0) ? 8'($urandom_range(255, 4))
                                          : 8'($urandom_range(3));
    c.red      = rand_byte();
    c.green    = rand_byte();
    c.blue     = rand_byte();
    c.level    = rand_byte();
    c.chip     = 1'($urandom_range(1));
    c.reg_addr = 8'($urandom_range(255));
    c.reg_data = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic write_limit(input logic [1:0] idx, input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_RED:   lim_red = v;
      CFG_GREEN: lim_green = v;
      CFG_BLUE:  lim_blue = v;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // checked at the falling edge so all updates of the rising edge have landed
  task automatic wait_drained();
    @(negedge clk);
    while (pending_cmds.size() != 0 || in_ch.valid || exp_writes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : run_p
    int counted;
    led_cmd_t c;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_RED;
    cfg_wdata      = 8'h00;
    in_ch.valid    = 1'b0;
    in_ch.func     = FN_COLOUR;
    in_ch.led      = 8'h00;
    in_ch.red      = 8'h00;
    in_ch.green    = 8'h00;
    in_ch.blue     = 8'h00;
    in_ch.level    = 8'h00;
    in_ch.chip     = 1'b0;
    in_ch.reg_addr = 8'h00;
    in_ch.reg_data = 8'h00;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    err_count      = 0;
    drv_cmd        = '0;
    for (int i = 0; i < 12; i++) colour_mem[i] = 8'h00;
    bright_lvl = BRIGHT_RST;
    lim_red    = RED_LIMIT_RST;
    lim_green  = GREEN_LIMIT_RST;
    lim_blue   = BLUE_LIMIT_RST;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      case (p)
        1: begin
          write_limit(CFG_RED, 8'hff);
          write_limit(CFG_GREEN, 8'hff);
          write_limit(CFG_BLUE, 8'hff);
        end
        2: begin
          write_limit(CFG_RED, 8'h00);
          write_limit(CFG_GREEN, 8'h00);
          write_limit(CFG_BLUE, 8'h00);
        end
        4: begin
          write_limit(CFG_RED, 8'hff);
          write_limit(CFG_GREEN, 8'h00);
          write_limit(CFG_BLUE, 8'h01);
        end
        3, 5: begin
          write_limit(CFG_RED, 8'($urandom_range(255)));
          write_limit(CFG_GREEN, 8'($urandom_range(255)));
          write_limit(CFG_BLUE, 8'($urandom_range(255)));
        end
        default: ;
      endcase

      if (p == 0) begin
        pending_cmds.push_back(make_cmd(FN_COLOUR, 8'd0, 8'hff, 8'hff, 8'hff, 8'h00,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_COLOUR, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_COLOUR, 8'd2, 8'hff, 8'h00, 8'h80, 8'h00,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_COLOUR, 8'd3, 8'h01, 8'hfe, 8'hff, 8'h00,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_COLOUR, 8'd4, 8'hff, 8'hff, 8'hff, 8'h00,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_COLOUR, 8'hff, 8'h11, 8'h22, 8'h33, 8'h00,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_COLOUR, 8'h80, 8'hc8, 8'h64, 8'h32, 8'h00,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_COLOUR, 8'd2, 8'hff, 8'hff, 8'hff, 8'h00,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_BRIGHT, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00,
                                        1'b1, 8'hff, 8'hff));
        pending_cmds.push_back(make_cmd(FN_BRIGHT, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_BRIGHT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_BRIGHT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_STBY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_WAKE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_INIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                        1'b0, 8'h00, 8'h00));
        // stored colours must read back as zero after init
        pending_cmds.push_back(make_cmd(FN_BRIGHT, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_RAW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                        1'b0, 8'h00, 8'h00));
        pending_cmds.push_back(make_cmd(FN_RAW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                        1'b1, 8'hff, 8'hff));
        pending_cmds.push_back(make_cmd(FN_RAW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                        1'b0, 8'h55, 8'haa));
        pending_cmds.push_back(make_cmd(FN_RAW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                        1'b1, 8'haa, 8'h55));
        // unused codes: nothing written, nothing stored
        pending_cmds.push_back(make_cmd(FN_NONE_A, 8'd1, 8'hff, 8'hff, 8'hff, 8'h00,
                                        1'b1, 8'h01, 8'h01));
        pending_cmds.push_back(make_cmd(FN_NONE_B, 8'd9, 8'hff, 8'hff, 8'hff, 8'h00,
                                        1'b1, 8'h01, 8'h01));
        pending_cmds.push_back(make_cmd(FN_BRIGHT, 8'h00, 8'h00, 8'h00, 8'h00, 8'hfe,
                                        1'b0, 8'h00, 8'h00));
      end

      counted = 0;
      while (counted < 65) begin
        c = rand_cmd();
        pending_cmds.push_back(c);
        if (c.func <= FN_RAW) counted++;
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("tb_rgb_led_bar_brightness_writer_core: done, clean");
    end else begin
      $display("tb_rgb_led_bar_brightness_writer_core: done, errors");
    end
    $finish;
  end

  initial begin : limit_p
    #5_000_000;
    $display("tb_rgb_led_bar_brightness_writer_core: done, errors");
    $finish;
  end

endmodule
